@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define BOCC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define BOCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bocc_pkg.sv @@
package bocc_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int NUM_STAGES = 4;

    // field and counter widths
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int PIX_CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
    localparam int LAG_W      = $clog2(NUM_STAGES * (MAX_WIDTH + 1) + 1);
    localparam int LINES      = 2;
    localparam int RAM_W      = LINES * NUM_STAGES;
    localparam int TDATA_W    = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'd1;
    localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_type_t;

    typedef enum logic {
        OP_ERODE  = 1'b0,
        OP_DILATE = 1'b1
    } morph_op_t;

    // erode, dilate, dilate, erode
    localparam morph_op_t STAGE_OP [NUM_STAGES] = '{OP_ERODE, OP_DILATE, OP_DILATE, OP_ERODE};

    // per-request advance of the stage chain
    typedef struct packed {
        logic                 adv;
        logic [PIX_CNT_W-1:0] virt;
    } adv_ctl_t;

    // geometry of the frame in progress
    typedef struct packed {
        logic [COL_W-1:0] wm1;
        logic [COL_W-1:0] wm2;
        logic [ROW_W-1:0] hm2;
    } geom_t;

    // result decision for the current request
    typedef struct packed {
        logic emit;
        logic last;
    } res_ctl_t;

    typedef struct packed {
        logic pixel_out;
        logic frame_last;
    } out_item_t;

endpackage

@@ sv/binary_open_close_3x3.sv @@
// a result is registered in the output buffer (main register, or skid while main is full) and shown on m_tvalid
// throughput: one request per cycle while s_tready is high; each pixel request passes all four 3x3 stages at once
// output pixel e leaves with input pixel e + 4*(W+1); the rest leave one per flush request
// the four stages share one line memory port pair (MAX_WIDTH words, one column per cycle while requests are accepted)
// reset: synchronous, active low; clears counters, output buffer, W=640, H=480
// line memory is not cleared; unwritten words only reach the forced-zero border ring
module binary_open_close_3x3 import bocc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,    // [0] pixel_in, rest zero
    input  logic [0:0]            s_tuser,    // [0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,    // [0] pixel_out, rest zero
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                             accept;
    req_type_t                        req_type;
    adv_ctl_t                         adv_ctl;
    geom_t                            geom;
    logic [NUM_STAGES-1:0][LAG_W-1:0] lag;
    logic                             ram_we;
    logic [COL_W-1:0]                 ram_waddr;
    logic [COL_W-1:0]                 ram_raddr;
    logic [NUM_STAGES-1:0][LINES-1:0] ram_wdata;
    logic [NUM_STAGES-1:0][LINES-1:0] ram_rdata;
    res_ctl_t                         res_ctl;
    logic [NUM_STAGES:0]              stream;
    out_item_t                        push_item;
    out_item_t                        m_item;

    assign accept   = s_tvalid && s_tready;
    assign req_type = req_type_t'(s_tuser[0]);

    // flush requests feed a dummy zero pixel into the chain
    assign stream[0] = (req_type == REQ_PIXEL) && s_tdata[0];

    bocc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req_type  (req_type),
        .adv_ctl   (adv_ctl),
        .geom      (geom),
        .lag       (lag),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_raddr (ram_raddr),
        .res_ctl   (res_ctl)
    );

    // two rows of history per stage, all in one memory word
    bocc_line_ram u_line_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr   (ram_raddr),
        .rd_data (ram_rdata)
    );

    // erode, dilate, dilate, erode in one pass
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        bocc_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (adv_ctl),
            .geom     (geom),
            .lag      (lag[k]),
            .op       (STAGE_OP[k]),
            .x_in     (stream[k]),
            .line_in  (ram_rdata[k]),
            .y_out    (stream[k+1]),
            .line_out (ram_wdata[k])
        );
    end

    assign push_item = '{pixel_out: stream[NUM_STAGES], frame_last: res_ctl.last};

    bocc_out_skid u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_ctl.emit),
        .push_item (push_item),
        .in_ready  (s_tready),
        .m_valid   (m_tvalid),
        .m_item    (m_item),
        .m_ready   (m_tready)
    );

    assign m_tdata = {{(TDATA_W-1){1'b0}}, m_item.pixel_out};
    assign m_tlast = m_item.frame_last;

endmodule

@@ sv/bocc_line_ram.sv @@
module bocc_line_ram import bocc_pkg::*; (
    input  logic             aclk,
    input  logic             we,
    input  logic [COL_W-1:0] waddr,
    input  logic [RAM_W-1:0] wdata,
    input  logic [COL_W-1:0] raddr,
    output logic [RAM_W-1:0] rd_data
);

    logic [RAM_W-1:0] mem [MAX_WIDTH];
    logic [RAM_W-1:0] rd_data_reg;

    // one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/bocc_stage.sv @@
module bocc_stage import bocc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  adv_ctl_t         ctl,
    input  geom_t            geom,
    input  logic [LAG_W-1:0] lag,
    input  morph_op_t        op,
    input  logic             x_in,
    input  logic [LINES-1:0] line_in,   // [0] one row back, [1] two rows back
    output logic             y_out,
    output logic [LINES-1:0] line_out
);

    logic [2:0]       col_a_reg;
    logic [2:0]       col_b_reg;
    logic [COL_W-1:0] col_pos_reg;
    logic [COL_W-1:0] col_pos_next;
    logic [ROW_W-1:0] row_pos_reg;
    logic [ROW_W-1:0] row_pos_next;
    logic [8:0]       win;
    logic             go;
    logic             interior;
    logic             op_val;

    // center pixel exists once the stream is a full row plus one ahead
    assign go = ctl.virt >= {{(PIX_CNT_W-LAG_W){1'b0}}, lag};

    // outer ring is forced to zero
    assign interior = go && (row_pos_reg != '0) && (row_pos_reg <= geom.hm2)
                      && (col_pos_reg != '0) && (col_pos_reg <= geom.wm2);

    // 3x3 window: two stored columns plus the incoming one
    assign win    = {col_a_reg, col_b_reg, line_in[1], line_in[0], x_in};
    assign op_val = (op == OP_ERODE) ? (&win) : (|win);
    assign y_out  = interior & op_val;

    // shift the line pair for this column
    assign line_out = {line_in[0], x_in};

    // raster position of the center pixel
    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (!go) begin
            col_pos_next = '0;
            row_pos_next = '0;
        end else if (col_pos_reg == geom.wm1) begin
            col_pos_next = '0;
            row_pos_next = row_pos_reg + ROW_W'(1);
        end else begin
            col_pos_next = col_pos_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end else if (ctl.adv) begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    // window columns
    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            col_a_reg <= col_b_reg;
            col_b_reg <= {line_in[1], line_in[0], x_in};
        end
    end

endmodule

@@ sv/bocc_ctrl.sv @@
`include "assert_macros.svh"

module bocc_ctrl import bocc_pkg::*; (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data,
    input  logic                            accept,
    input  req_type_t                       req_type,
    output adv_ctl_t                        adv_ctl,
    output geom_t                           geom,
    output logic [NUM_STAGES-1:0][LAG_W-1:0] lag,
    output logic                            ram_we,
    output logic [COL_W-1:0]                ram_waddr,
    output logic [COL_W-1:0]                ram_raddr,
    output res_ctl_t                        res_ctl
);

    logic [WID_W-1:0]                 width_cfg_reg;
    logic [HGT_W-1:0]                 height_cfg_reg;
    logic [PIX_CNT_W-1:0]             cnt_reg;
    logic [PIX_CNT_W-1:0]             cnt_next;
    logic [PIX_CNT_W-1:0]             total_reg;
    logic [PIX_CNT_W-1:0]             total_next;
    logic [PIX_CNT_W-1:0]             emitted_reg;
    logic [PIX_CNT_W-1:0]             emitted_next;
    logic [PIX_CNT_W-1:0]             virt_reg;
    logic [PIX_CNT_W-1:0]             virt_next;
    logic [COL_W-1:0]                 ptr_reg;
    logic [COL_W-1:0]                 ptr_next;
    logic [COL_W-1:0]                 wm1_reg;
    logic [COL_W-1:0]                 wm2_reg;
    logic [ROW_W-1:0]                 hm2_reg;
    logic [NUM_STAGES-1:0][LAG_W-1:0] lag_reg;
    logic [NUM_STAGES-1:0][LAG_W-1:0] lag_next;

    logic [WID_W-1:0]             w_cl;
    logic [HGT_W-1:0]             h_cl;
    logic [WID_W+HGT_W-1:0]       prod;
    logic [LAG_W-1:0]             lag_base;
    logic                         is_pix;
    logic                         start;
    logic                         start_req;
    logic                         go_last;
    logic                         last_pix;
    logic                         flush_ok;
    logic                         emit;
    logic                         adv;
    logic [PIX_CNT_W-1:0]         virt_cur;
    logic [COL_W-1:0]             ptr_cur;
    logic [COL_W-1:0]             wm1_cur;
    logic [COL_W-1:0]             ptr_adv;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_WIDTH: begin
                    width_cfg_reg <= cfg_data[WID_W-1:0];
                end
                CFG_IDX_HEIGHT: begin
                    height_cfg_reg <= cfg_data[HGT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // saturate geometry to the supported range
    always_comb begin
        if (width_cfg_reg < WID_W'(MIN_DIM)) begin
            w_cl = WID_W'(MIN_DIM);
        end else if (width_cfg_reg > WID_W'(MAX_WIDTH)) begin
            w_cl = WID_W'(MAX_WIDTH);
        end else begin
            w_cl = width_cfg_reg;
        end
        if (height_cfg_reg < HGT_W'(MIN_DIM)) begin
            h_cl = HGT_W'(MIN_DIM);
        end else if (height_cfg_reg > HGT_W'(MAX_HEIGHT)) begin
            h_cl = HGT_W'(MAX_HEIGHT);
        end else begin
            h_cl = height_cfg_reg;
        end
    end

    // frame size and per-stage lag, latched at frame start
    assign prod       = {{HGT_W{1'b0}}, w_cl} * {{WID_W{1'b0}}, h_cl};
    assign total_next = start_req ? prod[PIX_CNT_W-1:0] : total_reg;
    assign lag_base   = LAG_W'(w_cl) + LAG_W'(1);

    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            lag_next[k] = lag_base * LAG_W'(k + 1);
        end
    end

    // request classification
    assign is_pix    = (req_type == REQ_PIXEL);
    assign start     = is_pix && ((cnt_reg == '0) || (cnt_reg >= total_reg));
    assign start_req = accept && start;
    assign virt_cur  = start ? '0 : virt_reg;
    assign go_last   = !start
                       && (virt_cur >= {{(PIX_CNT_W-LAG_W){1'b0}}, lag_reg[NUM_STAGES-1]});
    assign last_pix  = !start && ((cnt_reg + PIX_CNT_W'(1)) == total_reg);
    assign flush_ok  = !is_pix && (total_reg != '0) && (cnt_reg >= total_reg)
                       && (emitted_reg < total_reg);
    assign emit      = accept && (is_pix ? (go_last || last_pix) : flush_ok);
    assign adv       = accept && (is_pix || flush_ok);

    // line memory column pointer, wraps at the frame width
    assign ptr_cur  = start ? '0 : ptr_reg;
    assign wm1_cur  = start ? COL_W'(w_cl - WID_W'(1)) : wm1_reg;
    assign ptr_adv  = (ptr_cur == wm1_cur) ? '0 : ptr_cur + COL_W'(1);
    assign ptr_next = adv ? ptr_adv : ptr_reg;

    // next values of the frame counters
    always_comb begin
        cnt_next     = cnt_reg;
        emitted_next = emitted_reg;
        virt_next    = virt_reg;
        if (accept && is_pix) begin
            cnt_next = start ? PIX_CNT_W'(1) : cnt_reg + PIX_CNT_W'(1);
        end
        if (start_req) begin
            emitted_next = '0;
        end else if (emit) begin
            emitted_next = emitted_reg + PIX_CNT_W'(1);
        end
        if (adv) begin
            virt_next = virt_cur + PIX_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            total_reg   <= '0;
            emitted_reg <= '0;
            virt_reg    <= '0;
            ptr_reg     <= '0;
            wm1_reg     <= '0;
            wm2_reg     <= '0;
            hm2_reg     <= '0;
            lag_reg     <= '0;
        end else begin
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            emitted_reg <= emitted_next;
            virt_reg    <= virt_next;
            ptr_reg     <= ptr_next;
            if (start_req) begin
                wm1_reg <= COL_W'(w_cl - WID_W'(1));
                wm2_reg <= COL_W'(w_cl - WID_W'(2));
                hm2_reg <= ROW_W'(h_cl - HGT_W'(2));
                lag_reg <= lag_next;
            end
        end
    end

    assign adv_ctl   = '{adv: adv, virt: virt_cur};
    assign geom      = '{wm1: wm1_reg, wm2: wm2_reg, hm2: hm2_reg};
    assign lag       = lag_reg;
    assign ram_we    = adv;
    assign ram_waddr = ptr_cur;
    assign ram_raddr = ptr_next;
    assign res_ctl   = '{emit: emit,
                         last: !start && ((emitted_reg + PIX_CNT_W'(1)) == total_reg)};

    `BOCC_ASSERT_IMPL(a_emit_bound, 1'b1, emitted_reg <= total_reg,
                      "more pixels out than frame size")
    `BOCC_ASSERT_NEXT(a_last_closes, res_ctl.emit && res_ctl.last,
                      emitted_reg == total_reg,
                      "frame end mark not at frame end")
    `BOCC_ASSERT_NEXT(a_spare_flush,
                      accept && !is_pix && (emitted_reg >= total_reg),
                      $stable(virt_reg) && $stable(ptr_reg),
                      "spare flush moved the stage chain")

endmodule

@@ sv/bocc_out_skid.sv @@
`include "assert_macros.svh"

module bocc_out_skid import bocc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t push_item,
    output logic      in_ready,
    output logic      m_valid,
    output out_item_t m_item,
    input  logic      m_ready
);

    logic      main_valid_reg;
    logic      main_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t main_item_reg;
    out_item_t main_item_next;
    out_item_t skid_item_reg;
    out_item_t skid_item_next;
    logic      pop;

    assign pop = main_valid_reg && m_ready;

    // two-entry output buffer: main register plus skid
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_item_next  = main_item_reg;
        skid_item_next  = skid_item_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_item_next  = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_item_next  = push_item;
                main_valid_next = 1'b1;
            end else begin
                skid_item_next  = push_item;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_item_reg <= main_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_item   = main_item_reg;

    `BOCC_ASSERT_IMPL(a_skid_order, skid_valid_reg, main_valid_reg,
                      "skid entry without main entry")
    `BOCC_ASSERT_NEXT(a_skid_drain, skid_valid_reg && pop,
                      main_valid_reg && !skid_valid_reg,
                      "skid entry not moved up")

endmodule

@@ tb/sv/bocc_pixel_checker.sv @@
module bocc_pixel_checker
    import bocc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,    // [0] pixel_in, rest zero
    input  logic [0:0]            s_tuser,    // [0] req_type
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_W-1:0]    m_tdata,    // [0] pixel_out, rest zero
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           fail_count,
    output int unsigned           pending_count
);

    localparam int unsigned PRINT_CAP = 100;

    // register contents as written
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;

    // geometry latched at the first pixel of the open frame
    int frm_w;
    int frm_h;
    int frm_total;
    int pix_seen;
    int pix_sent;
    int stage_fill [NUM_STAGES+1];

    // bit 0 holds the input frame, bit s the output of stage s
    bit [NUM_STAGES:0] planes [];

    out_item_t   cleaned_q [$];
    int unsigned mismatches = 0;
    int unsigned result_no;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t bocc check, result %0d: %s", $time, result_no, msg);
        mismatches++;
    endtask

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // run stage s forward up to pixel index upto (exclusive)
    function automatic void compute_stage(input int s, input int upto);
        int idx;
        int row;
        int col;
        logic all_set;
        logic any_set;
        bit v;
        while (stage_fill[s] < upto) begin
            idx = stage_fill[s];
            row = idx / frm_w;
            col = idx % frm_w;
            v = 1'b0;
            // outer ring of each stage stays zero
            if (row > 0 && row < frm_h - 1 && col > 0 && col < frm_w - 1) begin
                all_set = 1'b1;
                any_set = 1'b0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        all_set &= planes[(row + dr) * frm_w + col + dc][s - 1];
                        any_set |= planes[(row + dr) * frm_w + col + dc][s - 1];
                    end
                end
                v = (STAGE_OP[s - 1] == OP_ERODE) ? all_set : any_set;
            end
            planes[idx][s] = v;
            stage_fill[s]++;
        end
    endfunction

    // expected output pixel, if any, for one accepted request
    function automatic void predict_request(input req_type_t req, input logic pix);
        int lag;
        int lim;
        out_item_t item;
        if (req == REQ_PIXEL) begin
            // new frame when none is open or the open one has all its pixels
            if (pix_seen == 0 || pix_seen >= frm_total) begin
                frm_w = clamp_dim(int'(width_reg), MAX_WIDTH);
                frm_h = clamp_dim(int'(height_reg), MAX_HEIGHT);
                frm_total = frm_w * frm_h;
                pix_seen = 0;
                pix_sent = 0;
                foreach (stage_fill[i]) stage_fill[i] = 0;
                planes = new[frm_total];
            end
            planes[pix_seen][0] = pix;
            pix_seen++;
            stage_fill[0] = pix_seen;
            for (int s = 1; s <= NUM_STAGES; s++) begin
                lag = s * (frm_w + 1);
                if (pix_seen >= frm_total) lim = frm_total;
                else lim = (pix_seen > lag) ? pix_seen - lag : 0;
                compute_stage(s, lim);
            end
            if (stage_fill[NUM_STAGES] <= pix_sent) return;
        end else begin
            // early and surplus flushes release nothing
            if (frm_total == 0 || pix_seen < frm_total) return;
            if (pix_sent >= frm_total) return;
        end
        item.pixel_out  = planes[pix_sent][NUM_STAGES];
        item.frame_last = (pix_sent + 1 == frm_total);
        pix_sent++;
        cleaned_q.push_back(item);
    endfunction

    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            frm_w      = int'(WIDTH_RESET);
            frm_h      = int'(HEIGHT_RESET);
            frm_total  = 0;
            pix_seen   = 0;
            pix_sent   = 0;
            result_no  = 0;
            foreach (stage_fill[i]) stage_fill[i] = 0;
            cleaned_q.delete();
        end else begin
            // results first: they stem from requests of earlier edges
            if (m_tvalid && m_tready) begin
                if (cleaned_q.size() == 0) begin
                    report_mismatch("output pixel with nothing pending");
                end else begin
                    want = cleaned_q.pop_front();
                    if (m_tdata[0] !== want.pixel_out)
                        report_mismatch($sformatf("pixel_out %b, expected %b",
                                                  m_tdata[0], want.pixel_out));
                    if (m_tlast !== want.frame_last)
                        report_mismatch($sformatf("frame_last %b, expected %b",
                                                  m_tlast, want.frame_last));
                    if (m_tdata[TDATA_W-1:1] !== '0)
                        report_mismatch($sformatf("tdata padding %h, expected zero",
                                                  m_tdata[TDATA_W-1:1]));
                end
                result_no++;
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IDX_WIDTH: begin
                        width_reg = cfg_data[WID_W-1:0];
                    end
                    CFG_IDX_HEIGHT: begin
                        height_reg = cfg_data[HGT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // input requests
            if (s_tvalid && s_tready)
                predict_request(req_type_t'(s_tuser[0]), s_tdata[0]);
        end
        fail_count    <= mismatches;
        pending_count <= cleaned_q.size();
    end

endmodule

@@ tb/sv/binary_open_close_3x3_tb.sv @@
module binary_open_close_3x3_tb import bocc_pkg::*;;

    localparam int unsigned ITEM_TARGET     = 1550;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned DRAIN_CYCLES    = 20;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;    // [0] pixel_in, rest zero
    logic [0:0]            s_tuser   = '0;    // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;           // [0] pixel_out, rest zero
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned stall_cycles = 0;
    int unsigned issued = 0;
    logic        hold_off_req = 1'b0;
    bit          steady = 1'b0;

    // register contents as last written by the stimulus
    logic [WID_W-1:0] w_field = WIDTH_RESET;
    logic [HGT_W-1:0] h_field = HEIGHT_RESET;

    always #5 aclk = ~aclk;

    binary_open_close_3x3 u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bocc_pixel_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // watchdog on cycles without any accepted transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("binary_open_close_3x3_tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // output backpressure, with one long hold-off on request
    initial begin : ready_driver
        int unsigned mode;
        int unsigned span;
        bit          held;
        held = 1'b0;
        forever begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 99);
                if (mode < 45) span = $urandom_range(1, 40);
                else if (mode < 85) span = $urandom_range(1, 30);
                else if (mode < 95) span = $urandom_range(1, 8);
                else span = $urandom_range(20, 60);
                repeat (span) begin
                    if (mode < 45) m_tready <= 1'b1;
                    else if (mode < 85) m_tready <= 1'($urandom_range(0, 1));
                    else m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
        end
    end

    function automatic int unsigned next_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // one request on the input stream, followed by an optional gap
    task automatic push_request(input req_type_t req, input logic pix);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(TDATA_W-1){1'b0}}, pix};
        do @(posedge aclk); while (!s_tready);
        gap = next_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop sending and wait until every expected pixel has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_geometry(input logic [CFG_DATA_W-1:0] w_word,
                                 input logic [CFG_DATA_W-1:0] h_word,
                                 input bit set_w, input bit set_h);
        if (set_w) begin
            cfg_beat(CFG_IDX_WIDTH, w_word);
            w_field = w_word[WID_W-1:0];
        end
        if (set_h) begin
            cfg_beat(CFG_IDX_HEIGHT, h_word);
            h_field = h_word[HGT_W-1:0];
        end
        cfg_valid <= 1'b0;
    endtask

    // a whole frame of random pixels, then its flush requests
    task automatic run_frame(input int unsigned density, input bit drop_tail, input bit noisy);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned lag;
        int unsigned rest;
        int unsigned flushes;
        w = eff_dim(w_field, MAX_WIDTH);
        h = eff_dim(h_field, MAX_HEIGHT);
        total = w * h;
        lag = NUM_STAGES * (w + 1);
        rest = (total - 1 < lag) ? total - 1 : lag;
        for (int unsigned i = 0; i < total; i++) begin
            // stray flush while pixels are still missing
            if (noisy && i > 0 && $urandom_range(0, 99) < 3)
                push_request(REQ_FLUSH, 1'($urandom_range(0, 1)));
            push_request(REQ_PIXEL, $urandom_range(0, 99) < density);
        end
        // either a partial flush, so that the next frame drops the tail, or a full one
        if (drop_tail) flushes = $urandom_range(0, rest - 1);
        else flushes = rest + (noisy ? $urandom_range(0, 2) : 0);
        repeat (flushes) push_request(REQ_FLUSH, 1'($urandom_range(0, 1)));
        issued += total + flushes;
    endtask

    initial begin : stimulus
        int unsigned pick;
        int unsigned wd;
        int unsigned hd;
        int unsigned nframes;
        int unsigned dens;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // flush with no frame open
        push_request(REQ_FLUSH, 1'b1);
        wait_drained();

        // width 0 and height 2 both saturate to 3
        load_geometry(13'h1800, 13'd2, 1'b1, 1'b1);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) push_request(REQ_FLUSH, 1'b0);
            push_request(REQ_PIXEL, 1'b1);
        end
        push_request(REQ_FLUSH, 1'b0);
        // new frame drops the unflushed rest of the old one
        for (int i = 0; i < 9; i++) push_request(REQ_PIXEL, i[0]);
        // full flush plus one surplus flush
        for (int i = 0; i < 9; i++) push_request(REQ_FLUSH, i[0]);
        wait_drained();

        // output held off while the input keeps coming
        load_geometry(13'd16, 13'd12, 1'b1, 1'b1);
        hold_off_req <= 1'b1;
        steady = 1'b1;
        run_frame(90, 1'b0, 1'b0);
        steady = 1'b0;

        // random geometries and frames
        while (issued < ITEM_TARGET) begin
            wait_drained();
            pick = $urandom_range(0, 2);
            wd = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 14) : $urandom_range(15, 48);
            hd = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 24);
            load_geometry({2'($urandom_range(0, 3)), 11'(wd)}, 13'(hd), pick != 2, pick != 1);
            nframes = $urandom_range(1, 3);
            repeat (nframes) begin
                steady = ($urandom_range(0, 99) < 25);
                case ($urandom_range(0, 4))
                    0: dens = 10;
                    1: dens = 50;
                    2: dens = 85;
                    3: dens = 96;
                    default: dens = 100;
                endcase
                run_frame(dens, $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 30);
            end
            steady = 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("binary_open_close_3x3_tb: clean");
        else
            $display("binary_open_close_3x3_tb: errors");
        $finish;
    end

endmodule

@@ binary_open_close_3x3.f @@
+incdir+sv
sv/bocc_pkg.sv
sv/bocc_line_ram.sv
sv/bocc_stage.sv
sv/bocc_ctrl.sv
sv/bocc_out_skid.sv
sv/binary_open_close_3x3.sv
tb/sv/bocc_pixel_checker.sv
tb/sv/binary_open_close_3x3_tb.sv
